// ===== rtl/sos_pkg.sv =====
package sos_pkg;

  typedef enum logic [3:0] {
    OP_INSERT = 4'd0,
    OP_REMOVE = 4'd1,
    OP_EXISTS = 4'd2,
    OP_MIN    = 4'd3,
    OP_MAX    = 4'd4,
    OP_RMMIN  = 4'd5,
    OP_RMMAX  = 4'd6,
    OP_PRED   = 4'd7,
    OP_SUCC   = 4'd8,
    OP_PREDRM = 4'd9,
    OP_SUCCRM = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Which cell an operation points at: for select and for removal.
  typedef enum logic [2:0] {
    POS_NONE,
    POS_KEY,
    POS_FIRST,
    POS_LAST,
    POS_PRED,
    POS_SUCC
  } pos_mode_t;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic      ins;
    logic      rm;
    pos_mode_t mode;
  } cell_cmd_t;

  // Per-cell compare flags, seen by both neighbors.
  typedef struct packed {
    logic valid;
    logic lt;
    logic eq;
    logic gt;
  } cell_flags_t;

endpackage

// ===== rtl/sorted_ordered_set_top.sv =====
// Sorted set of distinct keys, held in a row of CAPACITY cells in ascending
// order. A transaction is taken at a rising edge with start high and busy
// low; busy is always low, so one transaction can be taken in every cycle.
// Each transaction gives exactly one result, registered on status, found_value
// and entry_count at the edge that took it and marked by done, which is high for a
// single cycle. The receiver cannot stall, so it must capture the result in that
// cycle. Throughput is one transaction per cycle:
// every cell compares the key against its own entry at once, and the cells
// shift toward a neighbor in the same cycle to open or close a slot. The
// set is empty after reset; no clearing pass is needed. Keys use the low
// KEY_BITS bits of key. An insert of a key already held reports a
// duplicate before fullness is checked. Empty sets and missing neighbors
// report not found, with found_value zero.
module sorted_ordered_set_top import sos_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  op,
  input  logic [31:0] key,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] found_value,
  output logic [4:0]  entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  // Edge slots at index 0 and CAPACITY+1 pad the chain at both ends.
  cell_flags_t         fl  [CAPACITY+2];
  logic [KEY_BITS-1:0] ent [CAPACITY+2];
  logic [KEY_BITS-1:0] pk  [CAPACITY];

  logic [KEY_BITS-1:0] key_int;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  cell_cmd_t           cmd;
  status_t             st;
  logic                any_eq;
  logic                any_gt;
  logic                empty;
  logic                full;
  logic [KEY_BITS-1:0] picked;

  assign busy    = 1'b0;
  assign key_int = KEY_BITS'(key);

  // Left edge reads as "below the key" so an insert lands at cell 0.
  assign fl[0]            = '{valid: 1'b0, lt: 1'b1, eq: 1'b0, gt: 1'b0};
  assign fl[CAPACITY+1]   = '{valid: 1'b0, lt: 1'b0, eq: 1'b0, gt: 1'b0};
  assign ent[0]           = '0;
  assign ent[CAPACITY+1]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sos_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk         (clk),
      .valid       (count > CW'(i)),
      .key         (key_int),
      .cmd         (cmd),
      .left_flags  (fl[i]),
      .right_flags (fl[i+2]),
      .left_entry  (ent[i]),
      .right_entry (ent[i+2]),
      .flags       (fl[i+1]),
      .entry       (ent[i+1]),
      .pick        (pk[i])
    );
  end

  // Sorted order makes any match or any greater key visible as a plain OR.
  always_comb begin
    any_eq = 1'b0;
    any_gt = 1'b0;
    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_eq = any_eq | fl[i+1].eq;
      any_gt = any_gt | fl[i+1].gt;
      picked = picked | pk[i];
    end
  end

  assign empty = (count == '0);
  assign full  = (count == CW'(CAPACITY));

  // Decode: status and the command broadcast to the cells.
  always_comb begin
    st       = ST_OK;
    cmd.ins  = 1'b0;
    cmd.rm   = 1'b0;
    cmd.mode = POS_NONE;
    unique case (op)
      OP_INSERT: begin
        if (any_eq) begin
          st = ST_DUPLICATE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      OP_REMOVE: begin
        cmd.mode = POS_KEY;
        if (any_eq) begin
          cmd.rm = 1'b1;
        end else begin
          st = ST_NOT_FOUND;
        end
      end
      OP_EXISTS: begin
        if (!any_eq) begin
          st = ST_NOT_FOUND;
        end
      end
      OP_MIN, OP_RMMIN: begin
        cmd.mode = POS_FIRST;
        if (empty) begin
          st = ST_NOT_FOUND;
        end else begin
          cmd.rm = (op == OP_RMMIN);
        end
      end
      OP_MAX, OP_RMMAX: begin
        cmd.mode = POS_LAST;
        if (empty) begin
          st = ST_NOT_FOUND;
        end else begin
          cmd.rm = (op == OP_RMMAX);
        end
      end
      OP_PRED, OP_PREDRM: begin
        cmd.mode = POS_PRED;
        if (!fl[1].lt) begin
          st = ST_NOT_FOUND;
        end else begin
          cmd.rm = (op == OP_PREDRM);
        end
      end
      OP_SUCC, OP_SUCCRM: begin
        cmd.mode = POS_SUCC;
        if (!any_gt) begin
          st = ST_NOT_FOUND;
        end else begin
          cmd.rm = (op == OP_SUCCRM);
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
    // Cells only move on an accepted transaction.
    if (!start) begin
      cmd.ins = 1'b0;
      cmd.rm  = 1'b0;
    end
  end

  always_comb begin
    priority if (cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cmd.rm) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= start;
    end
  end

  // Result payload: loaded on each accepted transaction, valid while done marks it.
  always_ff @(posedge clk) begin
    if (start) begin
      status      <= st;
      found_value <= (st == ST_OK) ? 32'(picked) : 32'd0;
      entry_count <= 5'(count_next);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    start |=> done)
    else $error("transaction gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !start |=> !done)
    else $error("result without a transaction");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> found_value == 32'd0)
    else $error("found value set on a failed transaction");

  for (genvar j = 0; j + 1 < CAPACITY; j++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      fl[j+2].valid |-> ent[j+1] < ent[j+2])
      else $error("cell chain out of order");
  end
`endif

endmodule

// ===== rtl/sos_cell.sv =====
module sos_cell import sos_pkg::*; #(
  parameter int KEY_BITS = 32
) (
  input  logic                clk,
  input  logic                valid,
  input  logic [KEY_BITS-1:0] key,
  input  cell_cmd_t           cmd,
  input  cell_flags_t         left_flags,
  input  cell_flags_t         right_flags,
  input  logic [KEY_BITS-1:0] left_entry,
  input  logic [KEY_BITS-1:0] right_entry,
  output cell_flags_t         flags,
  output logic [KEY_BITS-1:0] entry,
  output logic [KEY_BITS-1:0] pick
);

  logic [KEY_BITS-1:0] entry_next;
  logic                rm_here;
  logic                sel;

  always_comb begin
    flags.valid = valid;
    flags.lt    = valid && (entry < key);
    flags.eq    = valid && (entry == key);
    flags.gt    = valid && (entry > key);
  end

  // Cells at or after the removal point take their right neighbor.
  always_comb begin
    unique case (cmd.mode)
      POS_KEY:   rm_here = !flags.lt;
      POS_FIRST: rm_here = 1'b1;
      POS_PRED:  rm_here = !right_flags.lt;
      POS_SUCC:  rm_here = flags.gt;
      default:   rm_here = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd.mode)
      POS_FIRST: sel = valid && !left_flags.valid;
      POS_LAST:  sel = valid && !right_flags.valid;
      POS_PRED:  sel = flags.lt && !right_flags.lt;
      POS_SUCC:  sel = flags.gt && !left_flags.gt;
      default:   sel = 1'b0;
    endcase
  end

  assign pick = sel ? entry : '0;

  always_comb begin
    priority if (cmd.ins) begin
      if (flags.lt) begin
        entry_next = entry;
      end else if (left_flags.lt) begin
        entry_next = key;
      end else begin
        entry_next = left_entry;
      end
    end else if (cmd.rm && rm_here) begin
      entry_next = right_entry;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
